>>> rtl/wnf_pkg.sv
package wnf_pkg;

	localparam int DEF_MAX_HALF_LENGTH = 512;
	localparam int DEF_SAMPLE_BITS     = 16;

	localparam int BIN_W       = 10;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;

	// gain is Q0.16 plus one bit so that 1.0 is exact
	localparam int GAIN_W = 17;
	// psds*256 + beta*psdn
	localparam int DEN_W  = 49;
	// psds << 24
	localparam int REM_W  = 56;
	// divisor shifted by the top quotient bit
	localparam int SH_W   = DEN_W + GAIN_W - 1;

	localparam logic [15:0]      RST_SMOOTHING    = 16'd58982;
	localparam logic [15:0]      RST_NOISE_WEIGHT = 16'd256;
	localparam logic [31:0]      RST_NOISE_FLOOR  = 32'd0;
	localparam logic             RST_NOISE_UPDATE = 1'b1;
	localparam logic [BIN_W-1:0] RST_HALF_LENGTH  = 10'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMOOTHING,
		REG_NOISE_WEIGHT,
		REG_NOISE_FLOOR,
		REG_NOISE_UPDATE,
		REG_HALF_LENGTH
	} wnf_reg_idx_t;

	typedef struct packed {
		logic [15:0]      smoothing;
		logic [15:0]      noise_weight;
		logic [31:0]      noise_floor;
		logic             noise_update;
		logic [BIN_W-1:0] half_length;
	} wnf_cfg_t;

	// per-item control decided by the front
	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic             act;
		logic             last;
		logic [15:0]      alpha;
	} wnf_ctrl_t;

	localparam int CTRL_W = $bits(wnf_ctrl_t);

endpackage

>>> rtl/wnf_queue.sv
module wnf_queue #(
	parameter int W     = 8,
	parameter int DEPTH = wnf_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/wnf_front.sv
module wnf_front #(
	parameter int MAX_HALF_LENGTH = wnf_pkg::DEF_MAX_HALF_LENGTH,
	parameter int SAMPLE_BITS     = wnf_pkg::DEF_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wnf_pkg::wnf_cfg_t               cfg,
	input  logic                            init_done,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wnf_pkg::BIN_W-1:0]       bin_index,
	input  logic signed [SAMPLE_BITS-1:0]   target_re,
	input  logic signed [SAMPLE_BITS-1:0]   target_im,
	input  logic signed [SAMPLE_BITS-1:0]   noise_re,
	input  logic signed [SAMPLE_BITS-1:0]   noise_im,
	output logic                            push,
	output logic [wnf_pkg::CTRL_W+64+2*SAMPLE_BITS-1:0] push_data,
	input  logic                            full
);

	localparam int SB = SAMPLE_BITS;

	logic signed [2*SB-1:0] t_rr, t_ii, n_rr, n_ii;
	logic [2*SB:0]          t_sum, n_sum;
	logic [31:0]            t_pwr, n_raw, n_pwr;
	wnf_pkg::wnf_ctrl_t     ctrl;
	logic                   pff_q;

	assign s_tready = init_done && !full;
	assign push     = s_tvalid && s_tready;

	// instantaneous powers, saturated to 32 bits
	assign t_rr  = target_re * target_re;
	assign t_ii  = target_im * target_im;
	assign n_rr  = noise_re * noise_re;
	assign n_ii  = noise_im * noise_im;
	assign t_sum = {1'b0, t_rr} + {1'b0, t_ii};
	assign n_sum = {1'b0, n_rr} + {1'b0, n_ii};
	assign t_pwr = (65'(t_sum) > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(t_sum);
	assign n_raw = (65'(n_sum) > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(n_sum);
	assign n_pwr = (cfg.noise_update && (n_raw < cfg.noise_floor)) ? cfg.noise_floor : n_raw;

	always_comb begin
		ctrl.bin   = bin_index;
		ctrl.act   = (bin_index != '0) && (bin_index <= cfg.half_length)
		             && (32'(bin_index) <= 32'(MAX_HALF_LENGTH));
		ctrl.last  = (bin_index == cfg.half_length);
		// no smoothing until a frame has ended
		ctrl.alpha = pff_q ? cfg.smoothing : '0;
	end

	assign push_data = {ctrl, t_pwr, n_pwr, target_re, target_im};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pff_q <= 1'b0;
		end else if (push && ctrl.last) begin
			pff_q <= 1'b1;
		end
	end

endmodule

>>> rtl/wnf_div.sv
module wnf_div #(
	parameter int TAG_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [31:0]                 num,
	input  logic [wnf_pkg::DEN_W-1:0]   den,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_valid,
	output logic [wnf_pkg::GAIN_W-1:0]  quot,
	output logic [TAG_W-1:0]            out_tag
);

	localparam int NS    = wnf_pkg::GAIN_W;
	localparam int REM_W = wnf_pkg::REM_W;
	localparam int DEN_W = wnf_pkg::DEN_W;
	localparam int SH_W  = wnf_pkg::SH_W;

	logic [REM_W-1:0] rem_s [NS];
	logic [DEN_W-1:0] den_s [NS];
	logic [NS-1:0]    quo_s [NS];
	logic [TAG_W-1:0] tag_s [NS];
	logic [NS-1:0]    vld_s;

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic [REM_W-1:0] rem_in, rem_nx;
		logic [DEN_W-1:0] den_in;
		logic [NS-1:0]    quo_in, quo_nx;
		logic [TAG_W-1:0] tag_in;
		logic             vld_in;
		logic [SH_W-1:0]  sh;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in = {num, 24'b0};
			assign den_in = den;
			assign quo_in = '0;
			assign tag_in = in_tag;
			assign vld_in = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign tag_in = tag_s[i-1];
			assign vld_in = vld_s[i-1];
		end

		always_comb begin
			sh     = SH_W'(den_in) << (NS - 1 - i);
			ge     = (SH_W'(rem_in) >= sh);
			rem_nx = ge ? REM_W'(SH_W'(rem_in) - sh) : rem_in;
			quo_nx = quo_in;
			quo_nx[NS-1-i] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= rem_nx;
				den_s[i] <= den_in;
				quo_s[i] <= quo_nx;
				tag_s[i] <= tag_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_tag   = tag_s[NS-1];
	// zero denominator gives zero gain
	assign quot      = (den_s[NS-1] != '0) ? quo_s[NS-1] : '0;

endmodule

>>> rtl/wnf_back.sv
module wnf_back #(
	parameter int MAX_HALF_LENGTH = wnf_pkg::DEF_MAX_HALF_LENGTH,
	parameter int SAMPLE_BITS     = wnf_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wnf_pkg::wnf_cfg_t             cfg,
	output logic                          init_done,
	input  logic                          empty,
	input  logic [wnf_pkg::CTRL_W+64+2*SAMPLE_BITS-1:0] head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic signed [SAMPLE_BITS-1:0] out_re,
	output logic signed [SAMPLE_BITS-1:0] out_im,
	output logic [wnf_pkg::BIN_W-1:0]     out_bin,
	output logic                          frame_end
);

	localparam int SB     = SAMPLE_BITS;
	localparam int CTRL_W = wnf_pkg::CTRL_W;
	localparam int QW     = CTRL_W + 64 + 2 * SB;
	localparam int DEPTH  = MAX_HALF_LENGTH + 1;
	localparam int AW     = $clog2(DEPTH);
	localparam int GAIN_W = wnf_pkg::GAIN_W;
	localparam int DEN_W  = wnf_pkg::DEN_W;
	localparam int TAG_W  = CTRL_W + 2 * SB;

	logic adv;

	// queue head
	wnf_pkg::wnf_ctrl_t     c_h;
	logic [31:0]            pt_h, pn_h;
	logic signed [SB-1:0]   tre_h, tim_h;
	logic [AW-1:0]          addr_h;

	// clearing pass
	logic [AW-1:0] clr_q;
	logic          done_q;

	// PSD stores
	logic [31:0]   tpsd_mem [DEPTH];
	logic [31:0]   npsd_mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [31:0]   mem_wt, mem_wn;

	// stage 1
	logic                 v_s1;
	wnf_pkg::wnf_ctrl_t   c_s1;
	logic [31:0]          pt_s1, pn_s1, trd_s1, nrd_s1;
	logic signed [SB-1:0] tre_s1, tim_s1;
	logic [16:0]          a_comp;
	logic [48:0]          qt, qn;

	// stage 2
	logic                 v_s2;
	wnf_pkg::wnf_ctrl_t   c_s2;
	logic [48:0]          qt_s2, qn_s2;
	logic [31:0]          trd_s2, nrd_s2;
	logic signed [SB-1:0] tre_s2, tim_s2;
	logic                 hit3, hit4;
	logic [31:0]          t_prev, n_prev, t_new, n_new;
	logic [47:0]          t_prod, n_prod;
	logic [49:0]          t_acc, n_acc;

	// stage 3
	logic                 v_s3;
	wnf_pkg::wnf_ctrl_t   c_s3;
	logic [31:0]          psds_s3, psdn_s3;
	logic signed [SB-1:0] tre_s3, tim_s3;
	logic [47:0]          bn;

	// stage 4
	logic                 v_s4;
	wnf_pkg::wnf_ctrl_t   c_s4;
	logic [31:0]          psds_s4, psdn_s4;
	logic [47:0]          bn_s4;
	logic signed [SB-1:0] tre_s4, tim_s4;
	logic [DEN_W-1:0]     den;

	// divider out
	logic                 v_d;
	logic [GAIN_W-1:0]    gain;
	logic [TAG_W-1:0]     tag_d;
	wnf_pkg::wnf_ctrl_t   c_d;
	logic signed [SB-1:0] tre_d, tim_d;

	// gain multiply
	logic                 v_m;
	wnf_pkg::wnf_ctrl_t   c_m;
	logic signed [SB+17:0] pr_m, pi_m;
	logic signed [SB-1:0] tre_m, tim_m;
	logic signed [SB+17:0] rr, ri;

	// output register
	logic                 out_valid_q;
	logic signed [SB-1:0] out_re_q, out_im_q;
	logic [wnf_pkg::BIN_W-1:0] out_bin_q;
	logic                 frame_end_q;

	// the whole back pipeline moves together while the output can take a result
	assign adv       = !out_valid_q || m_tready;
	assign init_done = done_q;
	assign pop       = adv && !empty && done_q;

	assign c_h    = wnf_pkg::wnf_ctrl_t'(head[QW-1 -: CTRL_W]);
	assign pt_h   = head[2*SB+63 -: 32];
	assign pn_h   = head[2*SB+31 -: 32];
	assign tre_h  = head[2*SB-1 -: SB];
	assign tim_h  = head[SB-1:0];
	assign addr_h = AW'(c_h.bin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else if (!done_q) begin
			if (clr_q == AW'(MAX_HALF_LENGTH)) begin
				done_q <= 1'b1;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// write back from stage 2, or zero during the clearing pass
	assign mem_we = !done_q || (adv && v_s2 && c_s2.act);
	assign mem_wa = done_q ? AW'(c_s2.bin) : clr_q;
	assign mem_wt = done_q ? t_new : '0;
	assign mem_wn = done_q ? n_new : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tpsd_mem[mem_wa] <= mem_wt;
			npsd_mem[mem_wa] <= mem_wn;
		end
		if (adv) begin
			trd_s1 <= tpsd_mem[addr_h];
			nrd_s1 <= npsd_mem[addr_h];
		end
	end

	// stage 1: the (1 - alpha) * power terms
	assign a_comp = 17'h1_0000 - {1'b0, c_s1.alpha};
	assign qt     = a_comp * pt_s1;
	assign qn     = a_comp * pn_s1;

	// stage 2: forward fresh PSDs of the two items ahead, then close the recursion
	always_comb begin
		hit3   = v_s3 && c_s3.act && c_s2.act && (c_s3.bin == c_s2.bin);
		hit4   = v_s4 && c_s4.act && c_s2.act && (c_s4.bin == c_s2.bin);
		t_prev = hit3 ? psds_s3 : (hit4 ? psds_s4 : trd_s2);
		n_prev = hit3 ? psdn_s3 : (hit4 ? psdn_s4 : nrd_s2);
		t_prod = c_s2.alpha * t_prev;
		n_prod = c_s2.alpha * n_prev;
		t_acc  = 50'(t_prod) + 50'(qt_s2) + 50'd32768;
		n_acc  = 50'(n_prod) + 50'(qn_s2) + 50'd32768;
		t_new  = t_acc[47:16];
		// hold the stored noise PSD when updating is off
		n_new  = cfg.noise_update ? n_acc[47:16] : n_prev;
	end

	// stage 3: beta * noise PSD
	assign bn = cfg.noise_weight * psdn_s3;

	// stage 4: gain denominator
	assign den = DEN_W'({psds_s4, 8'b0}) + DEN_W'(bn_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1    <= c_h;
			pt_s1   <= pt_h;
			pn_s1   <= pn_h;
			tre_s1  <= tre_h;
			tim_s1  <= tim_h;

			c_s2    <= c_s1;
			qt_s2   <= qt;
			qn_s2   <= qn;
			trd_s2  <= trd_s1;
			nrd_s2  <= nrd_s1;
			tre_s2  <= tre_s1;
			tim_s2  <= tim_s1;

			c_s3    <= c_s2;
			psds_s3 <= t_new;
			psdn_s3 <= n_new;
			tre_s3  <= tre_s2;
			tim_s3  <= tim_s2;

			c_s4    <= c_s3;
			psds_s4 <= psds_s3;
			psdn_s4 <= psdn_s3;
			bn_s4   <= bn;
			tre_s4  <= tre_s3;
			tim_s4  <= tim_s3;

			c_m     <= c_d;
			pr_m    <= tre_d * $signed({1'b0, gain});
			pi_m    <= tim_d * $signed({1'b0, gain});
			tre_m   <= tre_d;
			tim_m   <= tim_d;
		end
	end

	wnf_div #(
		.TAG_W(TAG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s4),
		.num      (psds_s4),
		.den      (den),
		.in_tag   ({c_s4, tre_s4, tim_s4}),
		.out_valid(v_d),
		.quot     (gain),
		.out_tag  (tag_d)
	);

	assign c_d   = wnf_pkg::wnf_ctrl_t'(tag_d[TAG_W-1 -: CTRL_W]);
	assign tre_d = tag_d[2*SB-1 -: SB];
	assign tim_d = tag_d[SB-1:0];

	// round to nearest, ties up
	assign rr = pr_m + (SB+18)'(32768);
	assign ri = pi_m + (SB+18)'(32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_m         <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_m         <= v_d;
			out_valid_q <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_m) begin
			out_re_q    <= c_m.act ? rr[SB+15:16] : tre_m;
			out_im_q    <= c_m.act ? ri[SB+15:16] : tim_m;
			out_bin_q   <= c_m.bin;
			frame_end_q <= c_m.last;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign out_bin   = out_bin_q;
	assign frame_end = frame_end_q;

endmodule

>>> rtl/wiener_noise_filter.sv
// Channel   Dir  tdata fields (low bit up)                         tuser  tlast
// s_        in   bin_index, target_re, target_im, noise_re, noise_im  -      -
// m_        out  out_re, out_im, out_bin                           -      frame_end
// cfg_      in   write enable, register index, 32-bit write data   -      -
//
// One bin per cycle while m_tready holds high; m_tvalid follows the input transfer
// through the queue, four PSD stages, 17-stage gain divider, gain multiply, output register.
// After reset both PSD stores are swept to zero, entries 0 to MAX_HALF_LENGTH,
// with s_tready low; config writes are taken meanwhile.
// A stalled m_ side freezes the back pipeline; the four-entry queue keeps
// s_tready high until it fills.
module wiener_noise_filter #(
	parameter int MAX_HALF_LENGTH = wnf_pkg::DEF_MAX_HALF_LENGTH,
	parameter int SAMPLE_BITS     = wnf_pkg::DEF_SAMPLE_BITS,
	localparam int IN_W  = ((wnf_pkg::BIN_W + 4 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((wnf_pkg::BIN_W + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// bin_index, target_re, target_im, noise_re, noise_im
	input  logic [IN_W-1:0]                 s_tdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// out_re, out_im, out_bin
	output logic [OUT_W-1:0]                m_tdata,
	output logic                            m_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic                            cfg_we,
	input  logic [wnf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wnf_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int SB = SAMPLE_BITS;
	localparam int BW = wnf_pkg::BIN_W;
	localparam int QW = wnf_pkg::CTRL_W + 64 + 2 * SB;

	wnf_pkg::wnf_cfg_t    cfg_q;
	logic                 init_done;
	logic                 push, full, pop, empty;
	logic [QW-1:0]        push_data, head;
	logic signed [SB-1:0] out_re, out_im;
	logic [BW-1:0]        out_bin;

	// register file; the user must write it only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing    <= wnf_pkg::RST_SMOOTHING;
			cfg_q.noise_weight <= wnf_pkg::RST_NOISE_WEIGHT;
			cfg_q.noise_floor  <= wnf_pkg::RST_NOISE_FLOOR;
			cfg_q.noise_update <= wnf_pkg::RST_NOISE_UPDATE;
			cfg_q.half_length  <= wnf_pkg::RST_HALF_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				wnf_pkg::REG_SMOOTHING:    cfg_q.smoothing    <= cfg_wdata[15:0];
				wnf_pkg::REG_NOISE_WEIGHT: cfg_q.noise_weight <= cfg_wdata[15:0];
				wnf_pkg::REG_NOISE_FLOOR:  cfg_q.noise_floor  <= cfg_wdata[31:0];
				wnf_pkg::REG_NOISE_UPDATE: cfg_q.noise_update <= cfg_wdata[0];
				wnf_pkg::REG_HALF_LENGTH:  cfg_q.half_length  <= cfg_wdata[BW-1:0];
				default: ;
			endcase
		end
	end

	// front: classify each bin and compute its powers
	wnf_front #(
		.MAX_HALF_LENGTH(MAX_HALF_LENGTH),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.init_done(init_done),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.bin_index(s_tdata[BW-1:0]),
		.target_re(s_tdata[BW+SB-1 -: SB]),
		.target_im(s_tdata[BW+2*SB-1 -: SB]),
		.noise_re (s_tdata[BW+3*SB-1 -: SB]),
		.noise_im (s_tdata[BW+4*SB-1 -: SB]),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	// decouple front from back
	wnf_queue #(
		.W    (QW),
		.DEPTH(wnf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// back: PSD update, gain divide, scaling, output register
	wnf_back #(
		.MAX_HALF_LENGTH(MAX_HALF_LENGTH),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.init_done(init_done),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.out_re   (out_re),
		.out_im   (out_im),
		.out_bin  (out_bin),
		.frame_end(m_tlast)
	);

	assign m_tdata = OUT_W'({out_bin, out_im, out_re});

endmodule

>>> rtl/wnf_checker.sv
module wnf_checker #(
	parameter int MAX_HALF_LENGTH = wnf_pkg::DEF_MAX_HALF_LENGTH,
	parameter int SAMPLE_BITS     = wnf_pkg::DEF_SAMPLE_BITS,
	localparam int IN_W  = ((wnf_pkg::BIN_W + 4 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((wnf_pkg::BIN_W + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic [IN_W-1:0]               s_tdata,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [OUT_W-1:0]              m_tdata,
	input logic                          m_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic                          cfg_we,
	input logic [wnf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [wnf_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int BW = wnf_pkg::BIN_W;

	logic [BW-1:0] hl_q;
	logic [7:0]    cnt_q;
	logic [BW-1:0] out_bin;
	logic          in_xfer, out_xfer;

	assign out_bin  = m_tdata[2*SAMPLE_BITS+BW-1 -: BW];
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= wnf_pkg::RST_HALF_LENGTH;
		end else if (cfg_we && (cfg_index == wnf_pkg::REG_HALF_LENGTH)) begin
			hl_q <= cfg_wdata[BW-1:0];
		end
	end

	// bins in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("offered bin changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (out_bin == hl_q)))
		else $error("frame end does not match half length");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt_q != '0))
		else $error("result without an accepted bin");

endmodule

bind wiener_noise_filter wnf_checker #(
	.MAX_HALF_LENGTH(MAX_HALF_LENGTH),
	.SAMPLE_BITS    (SAMPLE_BITS)
) u_wnf_checker (.*);
